@@ design/cbra_pkg.sv @@
// Shared types and constants for the contiguous run bitmap allocator.
// Used by the controller, the datapath, the top level and the port checker.
// No dependencies.
package cbra_pkg;

  // Field widths of the stream items and the capacity register.
  localparam int unsigned RUN_W       = 7;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned CAP_W       = 7;
  localparam int unsigned HW_W        = 7;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 8;

  // Default slot count and capacity after reset.
  localparam int unsigned DEF_NUM_SLOTS = 64;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Input opcodes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_CAPACITY = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_FREE = 2'd2;

  // Outcome of one item, chosen by the controller and committed by the datapath.
  typedef enum logic [1:0] {
    RES_OK_ALLOC = 2'd0,
    RES_OK_FREE  = 2'd1,
    RES_ERR_CAP  = 2'd2,
    RES_ERR_FREE = 2'd3
  } res_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic start_at_mark;
    logic scan_step;
    logic check_step;
    logic fill_init;
    logic fill_step;
    logic clear_init;
    logic clear_step;
    logic push;
    res_e res;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_free;
    logic n_zero;
    logic fbm_zero;
    logic free_bad;
    logic scan_end;
    logic scan_hit;
    logic cur_bit;
    logic check_end;
    logic alloc_refuse;
    logic fill_end;
    logic out_free;
  } stat_t;

endpackage

@@ design/cbra_ctrl.sv @@
// Sequencing state machine of the contiguous run bitmap allocator.
// Depends on cbra_pkg for the command, status and result types.
module cbra_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cbra_pkg::stat_t stat_i,
  output cbra_pkg::cmd_t  cmd_o
);
  import cbra_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_START  = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_FILL   = 8'b0001_0000,
    S_CHECK  = 8'b0010_0000,
    S_CLEAR  = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  res_e   res_q, res_d;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= RES_OK_ALLOC;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.res = res_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        if (stat_i.op_free) begin
          if (stat_i.n_zero || stat_i.free_bad) begin
            res_d   = RES_ERR_FREE;
            state_d = S_RESP;
          end else begin
            state_d = S_CHECK;
          end
        end else if (stat_i.n_zero) begin
          res_d   = RES_ERR_CAP;
          state_d = S_RESP;
        end else if (stat_i.fbm_zero) begin
          cmd_o.start_at_mark = 1'b1;
          state_d             = S_DECIDE;
        end else begin
          state_d = S_SCAN;
        end
      end
      // First-fit scan below the mark, one slot per cycle.
      S_SCAN: begin
        if (stat_i.scan_end) begin
          state_d = S_DECIDE;
        end else begin
          cmd_o.scan_step = 1'b1;
          if (stat_i.scan_hit) begin
            state_d = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        if (stat_i.alloc_refuse) begin
          res_d   = RES_ERR_CAP;
          state_d = S_RESP;
        end else begin
          cmd_o.fill_init = 1'b1;
          state_d         = S_FILL;
        end
      end
      S_FILL: begin
        if (stat_i.fill_end) begin
          res_d   = RES_OK_ALLOC;
          state_d = S_RESP;
        end else begin
          cmd_o.fill_step = 1'b1;
        end
      end
      // Every slot of a freed run must be in use before any bit is cleared.
      S_CHECK: begin
        if (stat_i.check_end) begin
          cmd_o.clear_init = 1'b1;
          state_d          = S_CLEAR;
        end else if (!stat_i.cur_bit) begin
          res_d   = RES_ERR_FREE;
          state_d = S_RESP;
        end else begin
          cmd_o.check_step = 1'b1;
        end
      end
      S_CLEAR: begin
        if (stat_i.check_end) begin
          res_d   = RES_OK_FREE;
          state_d = S_RESP;
        end else begin
          cmd_o.clear_step = 1'b1;
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/cbra_datapath.sv @@
// Datapath of the contiguous run bitmap allocator: slot bitmap, mark, free count,
// capacity register, scan counters and the output register.
// Depends on cbra_pkg for widths, codes and the command and status structs.
module cbra_datapath #(
  parameter int unsigned NUM_SLOTS = cbra_pkg::DEF_NUM_SLOTS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_opcode_i,
  input  logic [cbra_pkg::RUN_W-1:0]  in_run_length_i,
  input  logic [cbra_pkg::SLOT_W-1:0] in_start_slot_i,
  input  logic                        cfg_we_i,
  input  logic [cbra_pkg::CAP_W-1:0]  cfg_data_i,
  input  cbra_pkg::cmd_t              cmd_i,
  output cbra_pkg::stat_t             stat_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [cbra_pkg::SLOT_W-1:0] out_slot_o,
  output logic [cbra_pkg::STAT_W-1:0] out_status_o
);
  import cbra_pkg::*;

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CNT_W = (IDX_W + 1 > RUN_W + 1) ? IDX_W + 1 : RUN_W + 1;
  localparam logic [CNT_W-1:0] NUM_SLOTS_C = CNT_W'(NUM_SLOTS);

  logic                 bitmap_q [NUM_SLOTS];
  logic                 rd_bit_q;
  logic                 op_q;
  logic [RUN_W-1:0]     n_q;
  logic [SLOT_W-1:0]    s_q;
  logic [CNT_W-1:0]     idx_q, run_q, start_q;
  logic [HW_W-1:0]      hw_q, fbm_q;
  logic [CAP_W-1:0]     cap_q;
  logic                 out_valid_q;
  logic [SLOT_W-1:0]    out_slot_q;
  logic [STAT_W-1:0]    out_status_q;

  logic [CNT_W-1:0] n_ext, hw_ext, cap_ext, lim, eff_cap, free_end, fill_end;
  logic [CNT_W-1:0] idx_d;
  logic [RUN_W-1:0] need;
  logic             cur_bit;

  // Limits and run ends.
  assign n_ext    = CNT_W'(n_q);
  assign hw_ext   = CNT_W'(hw_q);
  assign cap_ext  = CNT_W'(cap_q);
  assign lim      = (hw_ext < NUM_SLOTS_C) ? hw_ext : NUM_SLOTS_C;
  assign eff_cap  = (cap_ext < NUM_SLOTS_C) ? cap_ext : NUM_SLOTS_C;
  assign free_end = CNT_W'(s_q) + n_ext;
  assign fill_end = start_q + n_ext;
  assign need     = n_q - run_q[RUN_W-1:0];
  assign cur_bit  = (idx_q < NUM_SLOTS_C) ? rd_bit_q : 1'b1;

  // Status toward the controller.
  always_comb begin
    stat_o.op_free      = (op_q == OP_FREE);
    stat_o.n_zero       = (n_q == '0);
    stat_o.fbm_zero     = (fbm_q == '0);
    stat_o.free_bad     = (free_end > lim);
    stat_o.scan_end     = (idx_q >= lim);
    stat_o.scan_hit     = !cur_bit && ((run_q + CNT_W'(1)) == n_ext);
    stat_o.cur_bit      = cur_bit;
    stat_o.check_end    = (idx_q == free_end);
    stat_o.alloc_refuse = (need != '0) && (fill_end > eff_cap);
    stat_o.fill_end     = (idx_q == fill_end);
    stat_o.out_free     = !out_valid_q || out_ready_i;
  end

  // Slot index for the next cycle; the bitmap is read ahead at this index.
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = (in_opcode_i == OP_FREE) ? CNT_W'(in_start_slot_i) : '0;
    end else if (cmd_i.scan_step || cmd_i.check_step || cmd_i.fill_step ||
                 cmd_i.clear_step) begin
      idx_d = idx_q + CNT_W'(1);
    end else if (cmd_i.fill_init) begin
      idx_d = start_q;
    end else if (cmd_i.clear_init) begin
      idx_d = CNT_W'(s_q);
    end
  end

  // Slot bitmap memory, one bit written per cycle and read registered. Every slot
  // below the mark was written when the mark grew past it, and no slot at or above
  // the mark is ever read, so the memory needs no clearing after reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_step) begin
      bitmap_q[idx_q[IDX_W-1:0]] <= 1'b1;
    end else if (cmd_i.clear_step) begin
      bitmap_q[idx_q[IDX_W-1:0]] <= 1'b0;
    end
    rd_bit_q <= bitmap_q[idx_d[IDX_W-1:0]];
  end

  // Latched item and scan counters.
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.load) begin
      op_q    <= in_opcode_i;
      n_q     <= in_run_length_i;
      s_q     <= in_start_slot_i;
      run_q   <= '0;
      start_q <= '0;
    end else if (cmd_i.start_at_mark) begin
      start_q <= hw_ext;
    end else if (cmd_i.scan_step) begin
      if (cur_bit) begin
        run_q   <= '0;
        start_q <= idx_q + CNT_W'(1);
      end else begin
        run_q <= run_q + CNT_W'(1);
      end
    end
  end

  // Mark, free count, capacity register and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q        <= '0;
      fbm_q       <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
        case (cmd_i.res)
          RES_OK_ALLOC: begin
            fbm_q <= fbm_q - run_q[HW_W-1:0];
            hw_q  <= hw_q + HW_W'(need);
          end
          RES_OK_FREE: begin
            fbm_q <= fbm_q + HW_W'(n_q);
          end
          default: begin
          end
        endcase
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_slot_q <= (cmd_i.res == RES_OK_ALLOC) ? start_q[SLOT_W-1:0] : '0;
      case (cmd_i.res)
        RES_OK_ALLOC, RES_OK_FREE: out_status_q <= ST_OK;
        RES_ERR_CAP:               out_status_q <= ST_CAPACITY;
        default:                   out_status_q <= ST_BAD_FREE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_slot_o   = out_slot_q;
  assign out_status_o = out_status_q;

endmodule

@@ design/contiguous_run_bitmap_allocator.sv @@
// Sequence: an allocate scans first fit over the slots below the high-water mark (the scan
// covers at most the slots below the mark), then fills the run slot by slot.
// A free runs a check pass, then a clear pass over the run.
// Throughput: one item at a time; the single bitmap port steps one slot per cycle.
// A new item may be taken while the previous result still waits in the output register.
// Reset: mark and free count clear at once, so no slot reads as claimed; capacity returns to 64.
module contiguous_run_bitmap_allocator #(
  parameter int unsigned NUM_SLOTS = cbra_pkg::DEF_NUM_SLOTS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input items.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [cbra_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // run_length[6:0], start_slot[12:7]
  input  logic                             s_axis_tuser,  // opcode
  // Result items.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [cbra_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // granted_slot[5:0]
  output logic [cbra_pkg::STAT_W-1:0]      m_axis_tuser,  // status[1:0]
  // Capacity register write.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [cbra_pkg::CAP_W-1:0]       cfg_data_i
);
  import cbra_pkg::*;

  cmd_t              cmd;
  stat_t             stat;
  logic [SLOT_W-1:0] out_slot;
  logic              in_ready;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = in_ready;

  cbra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cbra_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_opcode_i     (s_axis_tuser),
    .in_run_length_i (s_axis_tdata[RUN_W-1:0]),
    .in_start_slot_i (s_axis_tdata[RUN_W+SLOT_W-1:RUN_W]),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_slot_o      (out_slot),
    .out_status_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - SLOT_W){1'b0}}, out_slot};

endmodule

@@ design/cbra_checker.sv @@
// Port-level checks for the contiguous run bitmap allocator, attached by bind.
// Depends on cbra_pkg and on the top level contiguous_run_bitmap_allocator.
module cbra_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [cbra_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [cbra_pkg::STAT_W-1:0]      m_axis_tuser
);
  import cbra_pkg::*;

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Only defined status codes appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_CAPACITY)
      || (m_axis_tuser == ST_BAD_FREE))
    else $error("undefined status code");

  // A refused or invalid request grants no slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata[SLOT_W-1:0] == '0))
    else $error("nonzero slot on error result");

  // The block works on one item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while one is in progress");

endmodule

bind contiguous_run_bitmap_allocator cbra_checker u_cbra_checker (.*);

@@ dv/cbra_result_checker.sv @@
// Result checker for the contiguous run bitmap allocator: watches the item, result and
// capacity channels, predicts each result and compares it field by field.
// Depends on cbra_pkg for widths, opcodes and status codes.
module cbra_result_checker #(
  parameter int unsigned NUM_SLOTS = cbra_pkg::DEF_NUM_SLOTS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_i,
  input  logic [cbra_pkg::IN_TDATA_W-1:0]  s_tdata_i,   // run_length[6:0], start_slot[12:7]
  input  logic                             s_tuser_i,   // opcode
  input  logic                             m_tvalid_i,
  input  logic                             m_tready_i,
  input  logic [cbra_pkg::OUT_TDATA_W-1:0] m_tdata_i,   // granted_slot[5:0]
  input  logic [cbra_pkg::STAT_W-1:0]      m_tuser_i,   // status[1:0]
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [cbra_pkg::CAP_W-1:0]       cfg_data_i,
  output int                               mismatch_count_o,
  output int                               outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cbra_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [STAT_W-1:0] status;
  } outcome_t;

  // Shadow copy of the allocator state and its capacity register.
  logic [NUM_SLOTS-1:0] slot_busy;
  logic [HW_W-1:0]      claim_mark;
  logic [HW_W-1:0]      free_below;
  logic [CAP_W-1:0]     capacity;

  outcome_t expected_outcomes_q[$];
  int       errors;

  function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
    errors++;
    if (errors <= 10) begin
      $display("%0t: mismatch in %s: expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // First-fit allocation or run release, applied to the shadow state.
  function automatic outcome_t compute_outcome(logic op, logic [RUN_W-1:0] len,
                                               logic [SLOT_W-1:0] first);
    outcome_t res;
    int unsigned lim, cap_eff, start, run, need, n, i;
    n = len;
    lim = (claim_mark < NUM_SLOTS) ? claim_mark : NUM_SLOTS;
    res.slot = '0;
    if (op == OP_ALLOC) begin
      res.status = ST_CAPACITY;
      if (n == 0) return res;
      cap_eff = (capacity < NUM_SLOTS) ? capacity : NUM_SLOTS;
      start = 0;
      run = 0;
      if (free_below != 0) begin
        for (i = 0; i < lim; i++) begin
          if (slot_busy[i]) begin
            run = 0;
            start = i + 1;
          end else begin
            run++;
            if (run == n) break;
          end
        end
      end else begin
        start = claim_mark;
      end
      need = n - run;
      // Only a run that grows past the mark is bounded by the capacity.
      if (need > 0 && start + n > cap_eff) return res;
      for (i = start; i < start + n && i < NUM_SLOTS; i++) slot_busy[i] = 1'b1;
      free_below = HW_W'(free_below - run);
      claim_mark = HW_W'(claim_mark + need);
      res.slot = SLOT_W'(start);
      res.status = ST_OK;
    end else begin
      res.status = ST_BAD_FREE;
      if (n == 0 || first + n > lim) return res;
      for (i = first; i < first + n; i++) begin
        if (!slot_busy[i]) return res;
      end
      for (i = first; i < first + n; i++) slot_busy[i] = 1'b0;
      free_below = HW_W'(free_below + n);
      res.status = ST_OK;
    end
    return res;
  endfunction

  // Results are compared before the item of the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      slot_busy = '0;
      claim_mark = '0;
      free_below = '0;
      capacity = CAP_RESET;
      expected_outcomes_q.delete();
      errors = 0;
      mismatch_count_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) capacity = cfg_data_i;
      if (m_tvalid_i && m_tready_i) begin
        if (expected_outcomes_q.size() == 0) begin
          note_mismatch("unexpected result, status", 0, m_tuser_i);
        end else begin
          want = expected_outcomes_q.pop_front();
          if (m_tdata_i[SLOT_W-1:0] != want.slot) begin
            note_mismatch("granted_slot", want.slot, m_tdata_i[SLOT_W-1:0]);
          end
          if (m_tuser_i != want.status) begin
            note_mismatch("status", want.status, m_tuser_i);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_outcomes_q.push_back(compute_outcome(s_tuser_i, s_tdata_i[RUN_W-1:0],
                                                      s_tdata_i[RUN_W +: SLOT_W]));
      end
      outstanding_o <= expected_outcomes_q.size();
      mismatch_count_o <= errors;
    end
  end

endmodule

@@ dv/contiguous_run_bitmap_allocator_test.sv @@
// Testbench top for the contiguous run bitmap allocator: clock, reset, directed and random
// allocate/free traffic over several capacity settings, and the final verdict.
// Depends on cbra_pkg, the allocator RTL and cbra_result_checker.
module contiguous_run_bitmap_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cbra_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef struct {
    int unsigned first;
    int unsigned len;
  } run_t;

  typedef struct packed {
    logic             op;
    logic [RUN_W-1:0] len;
  } request_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // run_length[6:0], start_slot[12:7]
  logic                   s_axis_tuser;   // opcode
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // granted_slot[5:0]
  logic [STAT_W-1:0]      m_axis_tuser;   // status[1:0]
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CAP_W-1:0]       cfg_data_i;

  int          mismatch_count;
  int          outstanding;
  int          gap_pct;
  int          stall_pct;
  int unsigned cycle_count;

  // Runs granted and not yet released, learned from the result stream.
  run_t     held_runs_q[$];
  request_t inflight_q[$];

  contiguous_run_bitmap_allocator i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  cbra_result_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tvalid_i      (s_axis_tvalid),
    .s_tready_i      (s_axis_tready),
    .s_tdata_i       (s_axis_tdata),
    .s_tuser_i       (s_axis_tuser),
    .m_tvalid_i      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_tdata_i       (m_axis_tdata),
    .m_tuser_i       (m_axis_tuser),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  always #10 clk_i = ~clk_i;

  // Result side stalls at the rate of the current phase.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Run timeout.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Pair each result with its request to learn which runs are held.
  always @(posedge clk_i) begin : track_grants
    request_t done;
    if (rst_ni && m_axis_tvalid && m_axis_tready && inflight_q.size() != 0) begin
      done = inflight_q.pop_front();
      if (done.op == OP_ALLOC && m_axis_tuser == ST_OK) begin
        held_runs_q.push_back('{first: m_axis_tdata[SLOT_W-1:0], len: done.len});
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      inflight_q.push_back('{op: s_axis_tuser, len: s_axis_tdata[RUN_W-1:0]});
    end
  end

  // One item transaction, preceded by a random gap; tvalid stays high afterwards.
  task automatic send_request(logic op, logic [RUN_W-1:0] len, logic [SLOT_W-1:0] first);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {{(IN_TDATA_W - RUN_W - SLOT_W){1'b0}}, first, len};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Holds the sender until every expected result has been taken.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly allocations of short runs and releases of held runs, with some malformed frees.
  task automatic issue_random_item();
    int unsigned r, k, a, m;
    run_t picked;
    logic [RUN_W-1:0] len;
    if (held_runs_q.size() == 0 || $urandom_range(99) < 50) begin
      r = $urandom_range(99);
      if (r < 3) len = '0;
      else if (r < 6) len = RUN_W'($urandom_range(65, 127));
      else if (r < 14) len = RUN_W'($urandom_range(9, 64));
      else len = RUN_W'($urandom_range(1, 8));
      send_request(OP_ALLOC, len, SLOT_W'($urandom()));
    end else if ($urandom_range(99) < 85) begin
      // Release all of a held run or a piece of it, keeping the remainder listed.
      k = $urandom_range(held_runs_q.size() - 1);
      picked = held_runs_q[k];
      held_runs_q.delete(k);
      if ($urandom_range(99) < 60) begin
        a = 0;
        m = picked.len;
      end else begin
        a = $urandom_range(picked.len - 1);
        m = $urandom_range(1, picked.len - a);
      end
      if (a > 0) held_runs_q.push_back('{first: picked.first, len: a});
      if (a + m < picked.len) begin
        held_runs_q.push_back('{first: picked.first + a + m, len: picked.len - a - m});
      end
      send_request(OP_FREE, RUN_W'(m), SLOT_W'(picked.first + a));
    end else begin
      r = $urandom_range(99);
      if (r < 15) len = '0;
      else if (r < 30) len = RUN_W'($urandom_range(65, 127));
      else len = RUN_W'($urandom_range(1, 8));
      send_request(OP_FREE, len, SLOT_W'($urandom_range(63)));
    end
  endtask

  task automatic run_phase(logic [CAP_W-1:0] cap, int in_gap, int out_stall, int count);
    drain_results();
    write_capacity(cap);
    gap_pct = in_gap;
    stall_pct = out_stall;
    repeat (count) issue_random_item();
  endtask

  initial begin
    gap_pct = 0;
    stall_pct = 0;
    cycle_count <= 0;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= OP_ALLOC;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    m_axis_tready <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset capacity.
    send_request(OP_ALLOC, 7'd0, 6'd0);      // zero-length allocate
    send_request(OP_FREE, 7'd0, 6'd0);       // zero-length free
    send_request(OP_FREE, 7'd1, 6'd0);       // free with nothing claimed yet
    send_request(OP_ALLOC, 7'd1, 6'd0);
    send_request(OP_ALLOC, 7'd3, 6'd63);
    send_request(OP_ALLOC, 7'd127, 6'd0);    // larger than any capacity
    send_request(OP_ALLOC, 7'd64, 6'd0);     // extension past the capacity
    send_request(OP_FREE, 7'd1, 6'd1);
    send_request(OP_FREE, 7'd1, 6'd1);       // double free
    send_request(OP_ALLOC, 7'd2, 6'd0);      // hole too small, grows at the mark
    send_request(OP_ALLOC, 7'd1, 6'd0);      // fills the hole
    send_request(OP_FREE, 7'd2, 6'd4);
    send_request(OP_ALLOC, 7'd3, 6'd0);      // free run at the mark is extended
    send_request(OP_FREE, 7'd1, 6'd63);      // beyond the mark
    send_request(OP_FREE, 7'd127, 6'd0);
    send_request(OP_FREE, 7'd3, 6'd2);       // spans two granted runs

    // Capacities rise so that the mark keeps growing; zero, saturation and lowering included.
    run_phase(7'd0, 0, 0, 80);
    run_phase(7'd12, 68, 0, 170);
    run_phase(7'd30, 0, 68, 170);
    run_phase(7'd127, 23, 23, 170);
    run_phase(7'd45, 0, 0, 170);
    run_phase(7'd64, 68, 68, 240);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
